/* rtl/core/wgm_pkg.sv */
// ---------------------------------------------------------------------------
// wgm_pkg
// Shared constants, register indexes and helpers for the glob matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package wgm_pkg;

  // Pattern store geometry
  localparam int StoreBytes = 32;
  localparam int NumWords   = 4;
  localparam int WordW      = 64;
  localparam int LenW       = 6;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int CharW      = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPatWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPatWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPatWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPatWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatLen   = 3'd4;

  // Pattern metacharacters
  localparam logic [CharW-1:0] StarChar = 8'h2A;
  localparam logic [CharW-1:0] AnyChar  = 8'h3F;

  // Case folding bounds
  localparam logic [CharW-1:0] UpperA    = 8'h41;
  localparam logic [CharW-1:0] UpperZ    = 8'h5A;
  localparam logic [CharW-1:0] CaseDelta = 8'h20;

  // Fold ASCII upper case to lower case, leave every other byte alone
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c + CaseDelta;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/wildcard_glob_matcher_unit.sv */
// ---------------------------------------------------------------------------
// wildcard_glob_matcher_unit
// Case-insensitive glob matcher ('*' and '?') over a streamed subject string.
// ---------------------------------------------------------------------------
//
//  channel   direction  payload                         when
//  --------  ---------  ------------------------------  ---------------------
//  cfg       in         pattern words 0..3, length      write strobe, no wait
//  s_axis    in         char_code, no_char, last        one subject byte
//  m_axis    out        matched                         once per subject
//
//  One item per cycle while no last item waits on a held result; an item is
//  registered in the input register, and a last item's result is loaded into the output register as it leaves.
//  The live-position update is a single bit-parallel pass with a prefix star
//  closure, so consecutive bytes follow each other without bubbles.
//  A last item waits in the input register only while a previous result is
//  still held on m_axis; bytes without last never wait.
//  Reset clears the pattern, the length and the live set (position zero).
//
`default_nettype none

module wildcard_glob_matcher_unit
  import wgm_pkg::*;
#(
  parameter int PatternMax = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write port
  input  wire logic                 cfg_we_i,
  input  wire logic [CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i,
  // subject byte stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [7:0]           s_axis_tdata,   // [7:0] char_code
  input  wire logic                 s_axis_tuser,   // [0] no_char
  input  wire logic                 s_axis_tlast,
  // match result stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic      [7:0]           m_axis_tdata    // [0] matched, [7:1] zero
);

  localparam int NumPos = (PatternMax < StoreBytes) ? PatternMax : StoreBytes;
  localparam int LiveW  = NumPos + 1;

  logic [NumWords-1:0][WordW-1:0] pattern_q;
  logic [LenW-1:0]                pattern_len_q;

  logic              stg_valid_q;
  logic [CharW-1:0]  stg_char_q;
  logic              stg_nochar_q;
  logic              stg_last_q;
  logic              stg_go;

  logic [LiveW-1:0]  live_q;
  logic [LiveW-1:0]  live_d;
  logic              matched_d;

  logic              out_valid_q;
  logic              out_matched_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q     <= '0;
      pattern_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPatWord0: pattern_q[0]  <= cfg_data_i;
        CfgPatWord1: pattern_q[1]  <= cfg_data_i;
        CfgPatWord2: pattern_q[2]  <= cfg_data_i;
        CfgPatWord3: pattern_q[3]  <= cfg_data_i;
        CfgPatLen:   pattern_len_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the staged item unless it carries a result that has nowhere to go
  assign stg_go        = stg_valid_q && (!stg_last_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !stg_valid_q || stg_go;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      stg_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      stg_char_q   <= s_axis_tdata;
      stg_nochar_q <= s_axis_tuser;
      stg_last_q   <= s_axis_tlast;
    end
  end

  // Live-position update for the staged byte
  wgm_live_step #(
    .NumPos (NumPos)
  ) u_step (
    .live_i        (live_q),
    .pattern_i     (pattern_q),
    .pattern_len_i (pattern_len_q),
    .char_code_i   (stg_char_q),
    .no_char_i     (stg_nochar_q),
    .last_i        (stg_last_q),
    .live_o        (live_d),
    .matched_o     (matched_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= LiveW'(1);
    end else if (stg_go) begin
      live_q <= live_d;
    end
  end

  // Output register: load on a last item, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stg_go && stg_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stg_go && stg_last_q) begin
      out_matched_q <= matched_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_matched_q};

  // A finished subject always produces a result on the next cycle
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_go && stg_last_q |=> m_axis_tvalid)
    else $error("last item did not load the output register");

  // A finished subject restarts from position zero
  a_live_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_go && stg_last_q |=> live_q == LiveW'(1))
    else $error("live set not restarted after last item");

  // A held result blocks a staged last item and the input with it
  a_last_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_valid_q && stg_last_q && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while a last item is blocked");

  // A new result appears only after a last item went through
  a_result_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(stg_go && stg_last_q))
    else $error("result without a last item");

endmodule

`default_nettype wire

/* rtl/core/wgm_live_step.sv */
// ---------------------------------------------------------------------------
// wgm_live_step
// One subject byte applied to the live pattern position set, with star
// closure, plus the end-of-subject match decision.
// ---------------------------------------------------------------------------
`default_nettype none

module wgm_live_step
  import wgm_pkg::*;
#(
  parameter int NumPos = 32
) (
  input  wire logic [NumPos:0]             live_i,
  input  wire logic [NumWords*WordW-1:0]   pattern_i,
  input  wire logic [LenW-1:0]             pattern_len_i,
  input  wire logic [CharW-1:0]            char_code_i,
  input  wire logic                        no_char_i,
  input  wire logic                        last_i,
  output logic      [NumPos:0]             live_o,
  output logic                             matched_o
);

  localparam int LiveW   = NumPos + 1;
  localparam int LenIdxW = (LiveW > 1) ? $clog2(LiveW) : 1;

  logic [LenW-1:0]    eff_len_full;
  logic [LenIdxW-1:0] eff_len;
  logic [NumPos-1:0]  in_range;
  logic [NumPos-1:0]  star_en;
  logic [NumPos-1:0]  byte_hit;
  logic [LiveW-1:0]   prop;
  logic [LiveW-1:0]   cur;
  logic [LiveW-1:0]   nxt;
  logic [LiveW-1:0]   live_upd;
  logic [LiveW-1:0]   closed_end;
  logic [CharW-1:0]   subj_fold;

  // Star closure as a parallel prefix: a live bit ripples through runs of stars
  function automatic logic [LiveW-1:0] star_close(input logic [LiveW-1:0] s,
                                                  input logic [LiveW-1:0] p);
    logic [LiveW-1:0] g;
    logic [LiveW-1:0] pp;
    g  = s;
    pp = p;
    for (int d = 1; d < LiveW; d = d * 2) begin
      g  = g | (pp & (g << d));
      pp = pp & (pp << d);
    end
    return g;
  endfunction

  // Clamp the length to the positions this instance holds
  assign eff_len_full = (pattern_len_i > LenW'(NumPos)) ? LenW'(NumPos) : pattern_len_i;
  assign eff_len      = eff_len_full[LenIdxW-1:0];
  assign subj_fold    = fold_char(char_code_i);

  // Classify each pattern position against the current byte
  always_comb begin
    logic [CharW-1:0] pb;
    for (int i = 0; i < NumPos; i++) begin
      pb          = pattern_i[CharW*i +: CharW];
      in_range[i] = (LenW'(i) < eff_len_full);
      star_en[i]  = in_range[i] && (pb == StarChar);
      byte_hit[i] = in_range[i] && (pb != StarChar) &&
                    ((pb == AnyChar) || (fold_char(pb) == subj_fold));
    end
  end

  // Position i+1 becomes reachable from position i through a star
  assign prop = {star_en, 1'b0};
  assign cur  = star_close(live_i, prop);

  // Advance: a star keeps its position, a matching byte moves one ahead
  assign nxt      = {byte_hit & cur[NumPos-1:0], 1'b0} |
                    {1'b0, star_en & cur[NumPos-1:0]};
  assign live_upd = no_char_i ? live_i : nxt;

  // Whole subject matched when the end of the pattern is reachable
  assign closed_end = star_close(live_upd, prop);
  assign matched_o  = closed_end[eff_len];

  // Restart from position zero after the last item
  assign live_o = last_i ? LiveW'(1) : live_upd;

endmodule

`default_nettype wire

/* dv/wildcard_glob_matcher_unit_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wildcard_glob_matcher_unit_tb
// Stream testbench for the case-insensitive glob matcher.
// Subject strings are streamed in against a series of patterns. A
// scoreboard tracks the live pattern positions of each subject on its own
// and checks every match flag in order. Both stream sides idle at random,
// and one long result hold-off forces the input to back up.
// ---------------------------------------------------------------------------

module wildcard_glob_matcher_unit_tb;
  import wgm_pkg::*;

  localparam int PatMax      = 32;
  localparam int TargetItems = 1400;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 4;
  localparam int HoldPhase   = 2;

  // First index past the register map; writes there must be ignored
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgPatLen + 3'd1;
  localparam logic [CharW-1:0]   LowerA    = 8'h61;
  localparam logic [CharW-1:0]   DigitZero = 8'h30;

  typedef struct {
    logic [CharW-1:0] code;
    logic             no_char;
    logic             last;
  } subj_item_t;

  // -------------------------------------------------------------------------
  // Match scoreboard: own copy of pattern, length and live position set
  // -------------------------------------------------------------------------
  class match_scoreboard;
    logic [WordW-1:0]    words [NumWords];
    logic [LenW-1:0]     len_reg;
    logic [StoreBytes:0] live;
    bit                  expected_matches [$];
    int                  errors;

    function new();
      for (int w = 0; w < NumWords; w++) begin
        words[w] = '0;
      end
      len_reg = '0;
      live    = 1;
      errors  = 0;
    endfunction

    function logic [CharW-1:0] pat_at(int pos);
      return words[pos / 8][(pos % 8) * 8 +: 8];
    endfunction

    // Clamp the length to the pattern store
    function int used_len();
      int n;
      n = int'(len_reg);
      if (n > PatMax) n = PatMax;
      if (n > StoreBytes) n = StoreBytes;
      return n;
    endfunction

    function logic [CharW-1:0] lower(logic [CharW-1:0] c);
      if (c >= UpperA && c <= UpperZ) return c + CaseDelta;
      return c;
    endfunction

    // Let every live position in front of a star reach past it
    function logic [StoreBytes:0] star_close(logic [StoreBytes:0] s, int n);
      for (int i = 0; i < n; i++) begin
        if (s[i] && pat_at(i) == StarChar) s[i+1] = 1'b1;
      end
      return s;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgPatWord0: words[0] = data;
        CfgPatWord1: words[1] = data;
        CfgPatWord2: words[2] = data;
        CfgPatWord3: words[3] = data;
        CfgPatLen:   len_reg  = data[LenW-1:0];
        default: ;
      endcase
    endfunction

    // Advance the live set by one accepted item, queue a flag on last
    function void note_item(logic [CharW-1:0] code, logic no_char, logic last);
      int                  n;
      logic [StoreBytes:0] cur;
      logic [StoreBytes:0] nxt;
      logic [CharW-1:0]    p;
      n = used_len();
      if (!no_char) begin
        cur = star_close(live, n);
        nxt = '0;
        for (int i = 0; i < n; i++) begin
          if (cur[i]) begin
            p = pat_at(i);
            if (p == StarChar) nxt[i] = 1'b1;
            else if (p == AnyChar || lower(p) == lower(code)) nxt[i+1] = 1'b1;
          end
        end
        live = nxt;
      end
      if (last) begin
        cur = star_close(live, n);
        expected_matches.push_back(cur[n]);
        live = 1;
      end
    endfunction

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [7:0] data);
      bit want;
      if (expected_matches.size() == 0) begin
        report($sformatf("match item 0x%02h with no subject outstanding", data));
        return;
      end
      want = expected_matches.pop_front();
      if (data[0] !== want) begin
        report($sformatf("matched: got %b, want %b", data[0], want));
      end
      if (data[7:1] !== 7'd0) begin
        report($sformatf("tdata pad bits not zero: 0x%02h", data));
      end
    endtask
  endclass

  // -------------------------------------------------------------------------
  // Clock, DUT and shared state
  // -------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [7:0] char_code
  logic                s_axis_tuser;   // [0] no_char
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [0] matched, [7:1] zero

  match_scoreboard sb;
  subj_item_t      tx_q [$];
  int              items_sent;
  bit              tx_fast;
  bit              rx_fast;
  bit              hold_off_req;

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  wildcard_glob_matcher_unit #(
    .PatternMax(PatMax)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // -------------------------------------------------------------------------
  // Stimulus helpers
  // -------------------------------------------------------------------------
  function automatic logic [CfgIdxW-1:0] word_index(int w);
    case (w)
      0:       return CfgPatWord0;
      1:       return CfgPatWord1;
      2:       return CfgPatWord2;
      default: return CfgPatWord3;
    endcase
  endfunction

  // Mostly a few letters in either case, so subjects collide with patterns
  function automatic logic [CharW-1:0] filler_byte();
    case ($urandom_range(0, 3))
      0:       return CharW'(LowerA + $urandom_range(0, 5));
      1:       return CharW'(UpperA + $urandom_range(0, 5));
      2:       return CharW'(DigitZero + $urandom_range(0, 9));
      default: return CharW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [CharW-1:0] pattern_pick();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return filler_byte();
      4, 5:       return StarChar;
      6, 7:       return AnyChar;
      default:    return CharW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_item(logic [CharW-1:0] c, logic nc, logic l);
    subj_item_t it;
    it.code    = c;
    it.no_char = nc;
    it.last    = l;
    tx_q.push_back(it);
  endfunction

  // Build a subject that fits the current pattern, optionally broken
  function automatic void add_subject(bit mutate, bit close_it);
    logic [CharW-1:0] bytes_q [$];
    logic [CharW-1:0] p;
    bit               flag_end;
    int               n;
    n = sb.used_len();
    for (int i = 0; i < n; i++) begin
      p = sb.pat_at(i);
      if (p == StarChar) begin
        repeat ($urandom_range(0, 3)) bytes_q.push_back(filler_byte());
      end else if (p == AnyChar) begin
        bytes_q.push_back(CharW'($urandom_range(0, 255)));
      end else if ((p >= UpperA && p <= UpperZ) || (p >= LowerA && p <= LowerA + 8'd25)) begin
        bytes_q.push_back($urandom_range(0, 1) ? (p ^ CaseDelta) : p);
      end else begin
        bytes_q.push_back(p);
      end
    end
    if (mutate) begin
      case ($urandom_range(0, 2))
        0: if (bytes_q.size() > 0) bytes_q[$urandom_range(0, bytes_q.size() - 1)] =
             CharW'($urandom_range(0, 255));
        1: if (bytes_q.size() > 0) bytes_q.delete($urandom_range(0, bytes_q.size() - 1));
        default: bytes_q.push_back(filler_byte());
      endcase
    end
    // End either on the last byte or with a separate no-byte item
    flag_end = close_it && (bytes_q.size() == 0 || $urandom_range(0, 7) == 0);
    for (int j = 0; j < bytes_q.size(); j++) begin
      if ($urandom_range(0, 11) == 0) add_item(CharW'($urandom_range(0, 255)), 1'b1, 1'b0);
      add_item(bytes_q[j], 1'b0, close_it && !flag_end && j == bytes_q.size() - 1);
    end
    if (flag_end) add_item(CharW'($urandom_range(0, 255)), 1'b1, 1'b1);
  endfunction

  // -------------------------------------------------------------------------
  // Drive tasks
  // -------------------------------------------------------------------------
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer queued items one by one, with a random gap before each
  task automatic send_queue();
    subj_item_t it;
    int         gap;
    while (tx_q.size() > 0) begin
      it  = tx_q.pop_front();
      gap = tx_fast ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.code;
      s_axis_tuser  <= it.no_char;
      s_axis_tlast  <= it.last;
      do @(posedge clk_i); while (s_axis_tready !== 1'b1);
      sb.note_item(it.code, it.no_char, it.last);
      if (!(it.no_char && !it.last)) items_sent++;
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold until every match flag is back and the last byte has settled
  task automatic wait_idle();
    while (sb.expected_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // New pattern: the first two phases use the all-ones and all-zero extremes
  task automatic random_pattern(int phase);
    logic [CfgDataW-1:0] w;
    int                  n;
    for (int widx = 0; widx < NumWords; widx++) begin
      if (phase < 2 || $urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 8; k++) begin
          if (phase == 0) w[k*8 +: 8] = 8'hFF;
          else if (phase == 1) w[k*8 +: 8] = 8'h00;
          else w[k*8 +: 8] = pattern_pick();
        end
        write_reg(word_index(widx), w);
      end
    end
    case ($urandom_range(0, 19))
      0, 1:       n = 0;
      2, 3:       n = $urandom_range(StoreBytes + 1, 63);
      4, 5, 6:    n = $urandom_range(13, StoreBytes);
      default:    n = $urandom_range(1, 12);
    endcase
    if (phase == 0) n = StoreBytes;
    if (phase == 1) n = 63;
    w = {$urandom(), $urandom()};
    w[LenW-1:0] = n[LenW-1:0];
    write_reg(CfgPatLen, w);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CfgIdxW'(CfgUnused + $urandom_range(0, 2)), {$urandom(), $urandom()});
    end
  endtask

  // -------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        stall        = HoldCycles;
        hold_off_req = 1'b0;
      end else if (rx_fast) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      sb.check_result(m_axis_tdata);
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog
  // -------------------------------------------------------------------------
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    int phase;
    int nsub;
    int pick;
    sb            = new();
    items_sent    = 0;
    tx_fast       = 1'b0;
    rx_fast       = 1'b0;
    hold_off_req  = 1'b0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgPatWord0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty pattern after reset: empty subject matches, one byte does not
    add_item(8'h00, 1'b1, 1'b1);
    add_item(8'hFF, 1'b0, 1'b1);
    send_queue();
    wait_idle();

    // Pattern "a*B?" plus a zero byte; bytes past the length are junk
    write_reg(CfgPatWord0, 64'hA5C3_7E00_3F42_2A61);
    write_reg(CfgPatLen, 64'd5);
    add_item(8'h41, 1'b0, 1'b0);
    add_item(8'h78, 1'b0, 1'b0);
    add_item(8'h00, 1'b1, 1'b0);
    add_item(8'h62, 1'b0, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    // Star taking no bytes
    add_item(8'h61, 1'b0, 1'b0);
    add_item(8'h62, 1'b0, 1'b0);
    add_item(8'h21, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b1);
    // Subject cut short by a no-byte last
    add_item(8'h61, 1'b0, 1'b0);
    add_item(8'hC3, 1'b1, 1'b1);
    // Open a subject, then shorten the pattern under it
    add_item(8'h61, 1'b0, 1'b0);
    send_queue();
    wait_idle();
    write_reg(CfgPatLen, 64'd1);
    add_item(8'h00, 1'b1, 1'b1);
    send_queue();
    wait_idle();

    // Bytes next to the letter ranges must not fold
    write_reg(CfgPatWord0, 64'h0000_0000_0000_5B40);
    write_reg(CfgPatLen, 64'd2);
    write_reg(CfgUnused, '1);
    add_item(8'h60, 1'b0, 1'b0);
    add_item(8'h7B, 1'b0, 1'b1);
    add_item(8'h40, 1'b0, 1'b0);
    add_item(8'h5B, 1'b0, 1'b1);
    send_queue();
    wait_idle();

    // Random phases, each with its own pattern and idle profile
    phase = 0;
    while (items_sent < TargetItems) begin
      random_pattern(phase);
      tx_fast = (phase % 4 == 3);
      rx_fast = ($urandom_range(0, 3) == 0);
      if (phase == HoldPhase) begin
        hold_off_req = 1'b1;
        tx_fast      = 1'b1;
      end
      nsub = $urandom_range(8, 20);
      for (int s = 0; s < nsub; s++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          repeat ($urandom_range(0, 5)) add_item(CharW'($urandom_range(0, 255)), 1'b0, 1'b0);
          add_item(CharW'($urandom_range(0, 255)), 1'b0, 1'b1);
        end else if (pick == 1) begin
          add_item(CharW'($urandom_range(0, 255)), 1'b1, 1'b1);
        end else begin
          add_subject(pick < 6, 1'b1);
        end
      end
      // Sometimes leave a subject open across the next pattern change
      if (phase >= 2 && $urandom_range(0, 6) == 0) add_subject(1'b0, 1'b0);
      send_queue();
      wait_idle();
      phase++;
    end

    // Close any open subject, then drain
    add_item(8'h00, 1'b1, 1'b1);
    send_queue();
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/wgm_pkg.sv
rtl/core/wgm_live_step.sv
rtl/core/wildcard_glob_matcher_unit.sv
dv/wildcard_glob_matcher_unit_tb.sv
